// ===== hw/rtl/first_fit_heap_allocator_assert.svh =====
// Assertion macros for the allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ffa_pkg.sv =====
package ffa_pkg;

  localparam int unsigned ADDR_W = 32;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_BAD_REL = 2'd2
  } status_t;

  // One table entry as stored in the chunk RAM.
  typedef struct packed {
    logic              used;
    logic [ADDR_W-1:0] payload;
    logic [ADDR_W-1:0] offset;
  } chunk_t;

  localparam int unsigned CHUNK_W = $bits(chunk_t);

endpackage

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// Channel  | Ports                                         | Transaction
// command  | start, busy, in_cmd, in_req_size, in_release_addr | start && !busy
// result   | out_valid, out_grant_addr, out_status         | out_valid, one cycle
// config   | cfg_we, cfg_addr, cfg_wdata                   | cfg_we
//
// Sequencing: a search reads the table entries one at a time (one read port on
// the chunk RAM, registered read). A split shifts the entries above the granted
// one up by one; a release checks both neighbors for a merge and shifts entries
// down to close the gap.
// Reset: synchronous, active low; table empty (chunk count zero).
// Config writes rebuild the table; issue them only while idle.
// The result sink cannot stall: out_valid is a one-cycle strobe.
module first_fit_heap_allocator
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS   = 64,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_cmd,
  input  logic [ADDR_W-1:0] in_req_size,
  input  logic [ADDR_W-1:0] in_release_addr,
  output logic              out_valid,
  output logic [ADDR_W-1:0] out_grant_addr,
  output logic [1:0]        out_status,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  `include "first_fit_heap_allocator_assert.svh"

  localparam int unsigned IW = $clog2(MAX_CHUNKS);
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam logic [ADDR_W-1:0] HDR   = ADDR_W'(HEADER_BYTES);
  // 1 - HEADER_BYTES: with ~req gives pay - req - HEADER_BYTES
  localparam logic [ADDR_W-1:0] HNEG1 = ADDR_W'(1) - ADDR_W'(HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CHUNKS);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SRD    = 14'b00000000000010, // issue search read
    S_SCHK   = 14'b00000000000100, // check searched entry
    S_SHRD   = 14'b00000000001000, // insert: read entry k-1
    S_SHWR   = 14'b00000000010000, // insert: write it to k
    S_SPLNEW = 14'b00000000100000, // write split remainder
    S_WRCUR  = 14'b00000001000000, // mark granted chunk used
    S_PRVRD  = 14'b00000010000000,
    S_PRVCHK = 14'b00000100000000,
    S_NXTRD  = 14'b00001000000000,
    S_NXTCHK = 14'b00010000000000,
    S_MRGWR  = 14'b00100000000000, // write merged chunk
    S_CPRD   = 14'b01000000000000, // compact: read k+r
    S_CPWR   = 14'b10000000000000  // compact: write to k
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     s_r, s_nxt;
  logic [1:0]        rm_r, rm_nxt;
  logic [ADDR_W-1:0] soff_r, soff_nxt;
  logic [ADDR_W-1:0] acc_r, acc_nxt;
  chunk_t            cur_r, cur_nxt;
  logic              split_r, split_nxt;
  logic              cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] req_r, req_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] heap_start_r, heap_start_nxt;
  logic [ADDR_W-1:0] heap_size_r, heap_size_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_grant_r, out_grant_nxt;
  status_t           out_status_r, out_status_nxt;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  chunk_t            ram_wdata;
  logic [CHUNK_W-1:0] ram_rdata;
  chunk_t            rd;

  // Shared three-input adder; operands chosen by state.
  logic [ADDR_W-1:0] add_a, add_b, add_c, add_sum;
  logic [ADDR_W+1:0] fit_need;
  logic              fits, can_split;
  logic [CW-1:0]     idx_inc;

  assign rd        = chunk_t'(ram_rdata);
  assign add_sum   = add_a + add_b + add_c;
  assign idx_inc   = idx_r + CW'(1);
  assign fit_need  = {2'b00, req_r} + (ADDR_W+2)'(HEADER_BYTES) + (ADDR_W+2)'(1);
  assign fits      = !rd.used && (rd.payload > req_r);
  assign can_split = ({2'b00, rd.payload} >= fit_need) && (count_r < CNT_MAX);

  ffa_ram #(
    .WIDTH(CHUNK_W),
    .DEPTH(MAX_CHUNKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    add_a = cur_r.offset;
    add_b = req_r;
    add_c = HDR;
    case (state_r)
      S_SCHK: begin
        if (cmd_r == CMD_RELEASE) begin
          add_a = heap_start_r;
          add_b = rd.offset;
        end else begin
          add_a = rd.payload;
          add_b = ~req_r;
          add_c = HNEG1;
        end
      end
      S_WRCUR: begin
        add_a = heap_start_r;
        add_b = cur_r.offset;
      end
      S_PRVCHK: begin
        add_a = rd.payload;
        add_b = cur_r.payload;
      end
      S_NXTCHK: begin
        add_a = acc_r;
        add_b = rd.payload;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    s_nxt          = s_r;
    rm_nxt         = rm_r;
    soff_nxt       = soff_r;
    acc_nxt        = acc_r;
    cur_nxt        = cur_r;
    split_nxt      = split_r;
    cmd_nxt        = cmd_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    heap_start_nxt = heap_start_r;
    heap_size_nxt  = heap_size_r;
    out_valid_nxt  = 1'b0;
    out_grant_nxt  = out_grant_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[IW-1:0];
    ram_wdata      = cur_r;
    ram_raddr      = idx_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          // rebuild: one free chunk covering the region, or nothing
          if (cfg_addr == 1'b0) begin
            heap_start_nxt = cfg_wdata;
          end else begin
            heap_size_nxt = cfg_wdata;
          end
          ram_we            = 1'b1;
          ram_waddr         = '0;
          ram_wdata.used    = 1'b0;
          ram_wdata.offset  = '0;
          ram_wdata.payload = heap_size_nxt - HDR;
          count_nxt         = (heap_size_nxt < HDR) ? '0 : CW'(1);
        end else if (start) begin
          cmd_nxt  = in_cmd;
          req_nxt  = in_req_size;
          addr_nxt = in_release_addr;
          idx_nxt  = '0;
          if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_grant_nxt  = '0;
            out_status_nxt = (in_cmd == CMD_RELEASE) ? ST_BAD_REL : ST_NO_FIT;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end

      S_SRD: begin
        state_nxt = S_SCHK;
      end

      S_SCHK: begin
        cur_nxt = rd;
        if (cmd_r == CMD_ALLOC && fits) begin
          acc_nxt   = add_sum;            // remainder payload if split
          split_nxt = can_split;
          k_nxt     = count_r;
          if (!can_split) begin
            state_nxt = S_WRCUR;
          end else if (count_r > idx_inc) begin
            state_nxt = S_SHRD;
          end else begin
            state_nxt = S_SPLNEW;
          end
        end else if (cmd_r == CMD_RELEASE && rd.used && add_sum == addr_r) begin
          acc_nxt  = rd.payload;
          s_nxt    = idx_r;
          soff_nxt = rd.offset;
          rm_nxt   = '0;
          if (idx_r != '0) begin
            state_nxt = S_PRVRD;
          end else if (idx_inc < count_r) begin
            state_nxt = S_NXTRD;
          end else begin
            state_nxt = S_MRGWR;
          end
        end else if (idx_inc == count_r) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_grant_nxt  = '0;
          out_status_nxt = (cmd_r == CMD_RELEASE) ? ST_BAD_REL : ST_NO_FIT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRD;
        end
      end

      S_SHRD: begin
        ram_raddr = IW'(k_r - CW'(1));
        state_nxt = S_SHWR;
      end

      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IW-1:0];
        ram_wdata = rd;
        k_nxt     = k_r - CW'(1);
        state_nxt = (k_nxt > idx_inc) ? S_SHRD : S_SPLNEW;
      end

      S_SPLNEW: begin
        ram_we            = 1'b1;
        ram_waddr         = idx_inc[IW-1:0];
        ram_wdata.used    = 1'b0;
        ram_wdata.payload = acc_r;
        ram_wdata.offset  = add_sum;      // offset + req + header
        count_nxt         = count_r + CW'(1);
        state_nxt         = S_WRCUR;
      end

      S_WRCUR: begin
        ram_we         = 1'b1;
        ram_wdata.used = 1'b1;
        if (split_r) begin
          ram_wdata.payload = req_r;
        end
        out_valid_nxt  = 1'b1;
        out_grant_nxt  = add_sum;
        out_status_nxt = ST_OK;
        state_nxt      = S_IDLE;
      end

      S_PRVRD: begin
        ram_raddr = IW'(idx_r - CW'(1));
        state_nxt = S_PRVCHK;
      end

      S_PRVCHK: begin
        if (!rd.used) begin
          acc_nxt  = add_sum;
          s_nxt    = idx_r - CW'(1);
          soff_nxt = rd.offset;
          rm_nxt   = 2'd1;
        end
        state_nxt = (idx_inc < count_r) ? S_NXTRD : S_MRGWR;
      end

      S_NXTRD: begin
        ram_raddr = idx_inc[IW-1:0];
        state_nxt = S_NXTCHK;
      end

      S_NXTCHK: begin
        if (!rd.used) begin
          acc_nxt = add_sum;
          rm_nxt  = rm_r + 2'd1;
        end
        state_nxt = S_MRGWR;
      end

      S_MRGWR: begin
        ram_we            = 1'b1;
        ram_waddr         = s_r[IW-1:0];
        ram_wdata.used    = 1'b0;
        ram_wdata.payload = acc_r;
        ram_wdata.offset  = soff_r;
        k_nxt             = s_r + CW'(1);
        if (rm_r != '0 && (k_nxt + CW'(rm_r)) < count_r) begin
          state_nxt = S_CPRD;
        end else begin
          count_nxt      = count_r - CW'(rm_r);
          out_valid_nxt  = 1'b1;
          out_grant_nxt  = '0;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      S_CPRD: begin
        ram_raddr = IW'(k_r + CW'(rm_r));
        state_nxt = S_CPWR;
      end

      S_CPWR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IW-1:0];
        ram_wdata = rd;
        k_nxt     = k_r + CW'(1);
        if ((k_nxt + CW'(rm_r)) < count_r) begin
          state_nxt = S_CPRD;
        end else begin
          count_nxt      = count_r - CW'(rm_r);
          out_valid_nxt  = 1'b1;
          out_grant_nxt  = '0;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      heap_start_r <= '0;
      heap_size_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      heap_start_r <= heap_start_nxt;
      heap_size_r  <= heap_size_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    s_r          <= s_nxt;
    rm_r         <= rm_nxt;
    soff_r       <= soff_nxt;
    acc_r        <= acc_nxt;
    cur_r        <= cur_nxt;
    split_r      <= split_nxt;
    cmd_r        <= cmd_nxt;
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    out_grant_r  <= out_grant_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_grant_addr = out_grant_r;
  assign out_status     = out_status_r;

  `FFA_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_MAX, "chunk count above table depth")
  `FFA_ASSERT_NEXT(a_start_busy, start && !busy && count_r != '0, busy,
    "accepted transaction did not start the sequencer")
  `FFA_ASSERT_NOW(a_fail_zero, out_valid && out_status != ST_OK, out_grant_addr == '0,
    "failed transaction carries a nonzero address")
  `FFA_ASSERT_NEXT(a_one_result, out_valid, !out_valid, "result strobe longer than one cycle")
  `FFA_ASSERT_NOW(a_split_room, state_r == S_SPLNEW, count_r < CNT_MAX,
    "split entered with a full table")

endmodule

// ===== hw/rtl/ffa_ram.sv =====
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Scoreboard: holds the expected grant/status pairs in order of acceptance.
class alloc_scoreboard;
  logic [31:0] exp_addr[$];
  logic [1:0]  exp_stat[$];
  int          errors;

  function void note_command(logic [31:0] addr, logic [1:0] stat);
    exp_addr.push_back(addr);
    exp_stat.push_back(stat);
  endfunction

  function void check_result(logic [31:0] addr, logic [1:0] stat);
    logic [31:0] ea;
    logic [1:0]  es;
    if (exp_addr.size() == 0) begin
      $display("%0t: unexpected result addr=%h status=%0d", $time, addr, stat);
      errors++;
      return;
    end
    ea = exp_addr.pop_front();
    es = exp_stat.pop_front();
    if (addr !== ea) begin
      $display("%0t: grant_addr mismatch expected %h actual %h", $time, ea, addr);
      errors++;
    end
    if (stat !== es) begin
      $display("%0t: status mismatch expected %0d actual %0d", $time, es, stat);
      errors++;
    end
  endfunction

  function int pending();
    return exp_addr.size();
  endfunction
endclass

module tb;
  import ffa_pkg::*;

  localparam int NCH  = 64;
  localparam int HDR  = 16;
  localparam int REG_START = 0;
  localparam int REG_SIZE  = 1;
  localparam longint LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = CMD_ALLOC;
  logic [31:0] in_req_size = '0;
  logic [31:0] in_release_addr = '0;
  logic        out_valid;
  logic [31:0] out_grant_addr;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [31:0] cfg_wdata = '0;

  first_fit_heap_allocator #(.MAX_CHUNKS(NCH), .HEADER_BYTES(HDR)) uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alloc_scoreboard sb = new();

  // Predictor copy of the chunk table
  logic [31:0] heap_base, heap_bytes;
  logic [31:0] ch_off[NCH];
  logic [31:0] ch_pay[NCH];
  logic        ch_used[NCH];
  int          ch_cnt;
  int          idle_pct;     // sender gap probability in percent
  longint      cycles;

  // Grants that are currently live, for well-formed releases.
  logic [31:0] live[$];

  function automatic logic [31:0] pay_addr(int i);
    return heap_base + ch_off[i] + HDR;
  endfunction

  function automatic void rebuild();
    if (heap_bytes < HDR) ch_cnt = 0;
    else begin
      ch_cnt = 1;
      ch_off[0] = 0;
      ch_pay[0] = heap_bytes - HDR;
      ch_used[0] = 1'b0;
    end
  endfunction

  function automatic void drop(int i);
    for (int k = i; k + 1 < ch_cnt; k++) begin
      ch_off[k] = ch_off[k+1];
      ch_pay[k] = ch_pay[k+1];
      ch_used[k] = ch_used[k+1];
    end
    ch_cnt--;
  endfunction

  // Computes the response of one command and updates the table.
  function automatic void predict_alloc(logic cmd, logic [31:0] req, logic [31:0] addr,
                                        output logic [31:0] ga, output logic [1:0] st);
    int i;
    i = -1;
    ga = '0;
    if (cmd == CMD_ALLOC) begin
      for (int k = 0; k < ch_cnt; k++)
        if (i < 0 && !ch_used[k] && ch_pay[k] > req) i = k;
      if (i < 0) begin
        st = ST_NO_FIT;
        return;
      end
      if ({32'd0, ch_pay[i]} >= {32'd0, req} + HDR + 1 && ch_cnt < NCH) begin
        for (int k = ch_cnt; k > i + 1; k--) begin
          ch_off[k] = ch_off[k-1];
          ch_pay[k] = ch_pay[k-1];
          ch_used[k] = ch_used[k-1];
        end
        ch_off[i+1] = ch_off[i] + HDR + req;
        ch_pay[i+1] = ch_pay[i] - req - HDR;
        ch_used[i+1] = 1'b0;
        ch_pay[i] = req;
        ch_cnt++;
      end
      ch_used[i] = 1'b1;
      ga = pay_addr(i);
      st = ST_OK;
    end else begin
      for (int k = 0; k < ch_cnt; k++)
        if (i < 0 && ch_used[k] && pay_addr(k) == addr) i = k;
      if (i < 0) begin
        st = ST_BAD_REL;
        return;
      end
      ch_used[i] = 1'b0;
      if (i > 0 && !ch_used[i-1]) begin
        ch_pay[i-1] = ch_pay[i-1] + ch_pay[i] + HDR;
        drop(i);
        i--;
      end
      if (i + 1 < ch_cnt && !ch_used[i+1]) begin
        ch_pay[i] = ch_pay[i] + ch_pay[i+1] + HDR;
        drop(i + 1);
      end
      st = ST_OK;
    end
  endfunction

  // Result monitor; the sink never stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) sb.check_result(out_grant_addr, out_status);
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * NCH + 20) @(posedge clk);
  endtask

  // Config write while idle; predictor rebuilds the table too.
  task automatic write_reg(int idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx[0];
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START) heap_base = val;
    else heap_bytes = val;
    rebuild();
    live.delete();
    @(posedge clk);
  endtask

  task automatic set_heap(logic [31:0] base, logic [31:0] size);
    wait_drain();
    write_reg(REG_START, base);
    write_reg(REG_SIZE, size);
  endtask

  // Issue one command transaction; start stays high until the sequencer is idle again.
  task automatic send_cmd(logic cmd, logic [31:0] req, logic [31:0] addr);
    logic [31:0] ga;
    logic [1:0]  st;
    do @(posedge clk); while ($urandom_range(99) < idle_pct);
    start <= 1'b1;
    in_cmd <= cmd;
    in_req_size <= req;
    in_release_addr <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    predict_alloc(cmd, req, addr, ga, st);
    sb.note_command(ga, st);
    if (cmd == CMD_ALLOC && st == ST_OK) live.push_back(ga);
    if (cmd == CMD_RELEASE && st == ST_OK)
      foreach (live[j]) if (live[j] == addr) begin
        live.delete(j);
        break;
      end
  endtask

  task automatic rand_item();
    int r;
    int j;
    logic [31:0] sz;
    r = $urandom_range(99);
    if (r < 50) begin
      // mostly small requests, sometimes wide random ones
      sz = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(200);
      send_cmd(CMD_ALLOC, sz, $urandom());
    end else if (r < 88 && live.size() > 0) begin
      j = $urandom_range(live.size() - 1);
      send_cmd(CMD_RELEASE, $urandom(), live[j]);
    end else begin
      send_cmd(CMD_RELEASE, $urandom(), $urandom());
    end
  endtask

  initial begin
    int phase;
    cycles = 0;
    idle_pct = 0;
    heap_base = 0;
    heap_bytes = 0;
    ch_cnt = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table after reset
    send_cmd(CMD_ALLOC, 0, 0);
    send_cmd(CMD_RELEASE, 0, 32'h10);
    // Heap below a header stays empty
    set_heap(32'h1000, HDR - 1);
    send_cmd(CMD_ALLOC, 0, 0);
    // Exactly one header: zero-byte payload never fits
    set_heap(32'h1000, HDR);
    send_cmd(CMD_ALLOC, 0, 0);
    // One-byte payload, zero-byte request fits, no split
    set_heap(32'hFFFF_FFF0, HDR + 1);
    send_cmd(CMD_ALLOC, 0, 0);
    send_cmd(CMD_RELEASE, 0, 32'h0);   // wrapped payload address
    send_cmd(CMD_RELEASE, 0, 32'h0);   // now free: bad release
    // Full-range heap, extreme requests and merges
    set_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 0);
    send_cmd(CMD_ALLOC, 32'hFFFF_FFEE, 0);
    send_cmd(CMD_RELEASE, 0, live[0]);
    send_cmd(CMD_ALLOC, 10, 0);
    send_cmd(CMD_ALLOC, 20, 0);
    send_cmd(CMD_ALLOC, 30, 0);
    send_cmd(CMD_RELEASE, 0, live[0]);
    send_cmd(CMD_RELEASE, 0, live[1]);
    send_cmd(CMD_RELEASE, 0, live[0]);  // merges both sides
    send_cmd(CMD_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill the table so splits are skipped
    set_heap(32'h0, 32'd4096);
    for (int k = 0; k < NCH + 2; k++) send_cmd(CMD_ALLOC, 4, 0);

    // Random phases over several heap settings
    for (phase = 0; phase < 9; phase++) begin
      idle_pct = (phase < 3) ? 17 : (phase < 6) ? 82 : 0;
      case (phase % 3)
        0: set_heap($urandom(), 16'd2000 + $urandom_range(3000));
        1: set_heap($urandom(), $urandom());
        default: set_heap(32'hFFFF_FF00, 32'd600);
      endcase
      for (int k = 0; k < 85; k++) begin
        rand_item();
        if (k == 50) while (sb.pending() != 0) @(posedge clk);
      end
    end

    wait_drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
